// ----- rtl/dmx512_frame_receiver_unit_assert.svh -----
// Assertion macros for the DMX512 frame receiver.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef DMX512_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define DMX512_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define DMX_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define DMX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dmx_pkg.sv -----
// Shared constants for the DMX512 frame receiver.
// No dependencies; used by the channel interfaces and the top level.
package dmx_pkg;

    localparam int FRAME_SLOTS_DEF = 513;

    localparam int OPCODE_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int SLOT_IN_W = 10;
    localparam int COUNT_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [OPCODE_W-1:0] OP_BYTE     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_BREAK    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_OVERFLOW = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ     = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_RESTART  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;

    localparam logic [TIME_W-1:0] DEBOUNCE_RESET = 32'd160000;

endpackage

// ----- rtl/dmx_ifs.sv -----
// Valid/ready channel interfaces of the DMX512 frame receiver.
// Depends on dmx_pkg for field widths.
interface dmx_item_if;
    logic                                valid;
    logic                                ready;
    logic [dmx_pkg::OPCODE_W-1:0]        opcode;
    logic [dmx_pkg::BYTE_W-1:0]          data_byte;
    logic [dmx_pkg::TIME_W-1:0]          break_time;
    logic [dmx_pkg::SLOT_IN_W-1:0]       read_slot;

    modport source (output valid, opcode, data_byte, break_time, read_slot, input ready);
    modport sink   (input valid, opcode, data_byte, break_time, read_slot, output ready);
endinterface

interface dmx_result_if;
    logic                                valid;
    logic                                ready;
    logic                                frame_published;
    logic [dmx_pkg::COUNT_W-1:0]         channel_count;
    logic                                break_accepted;
    logic [dmx_pkg::BYTE_W-1:0]          read_data;
    logic                                read_valid;

    modport source (output valid, frame_published, channel_count, break_accepted,
                    read_data, read_valid, input ready);
    modport sink   (input valid, frame_published, channel_count, break_accepted,
                    read_data, read_valid, output ready);
endinterface

interface dmx_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dmx_pkg::CFG_IDX_W-1:0]       index;
    logic [dmx_pkg::CFG_DAT_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/dmx512_frame_receiver_unit.sv -----
// Top level of the DMX512 frame receiver: frame assembly, two-bank slot store, result pipe.
// Depends on dmx_pkg, the channel interfaces in dmx_ifs.sv and the assertion header.
//
//  channel   dir  beat carries
//  -------   ---  -------------------------------------------------------------
//  item      in   opcode, data_byte, break_time, read_slot
//  result    out  frame_published, channel_count, break_accepted, read_data, read_valid
//  cfg       in   index, data (0 enable, 1 break_debounce); always ready
//
// Cycles: one item per cycle sustained while results are taken; each result
//   is registered in the read stage and the store's read port, then in the output register.
// Reset: control state, enable (1) and break_debounce (160000) reset at once; the slot
//   store is not cleared and needs no clearing pass.
// Stalls: the item channel stays ready while the read stage or output register can move;
//   a held result freezes the read stage and its store output register.
`include "dmx512_frame_receiver_unit_assert.svh"

module dmx512_frame_receiver_unit #(
    parameter int FRAME_SLOTS = dmx_pkg::FRAME_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    dmx_item_if.sink            item,
    dmx_result_if.source        result,
    dmx_cfg_if.sink             cfg
);

    // Slot index width within one bank, and width of a length that can reach FRAME_SLOTS.
    localparam int SLOT_W    = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam int LEN_W     = $clog2(FRAME_SLOTS + 1);
    localparam int ADDR_W    = SLOT_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int CMP_W     = ((LEN_W > dmx_pkg::SLOT_IN_W) ? LEN_W : dmx_pkg::SLOT_IN_W) + 1;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(FRAME_SLOTS);
    localparam logic [LEN_W-1:0] LEN_ONE  = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO  = LEN_W'(2);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                           enable_reg;
    logic [dmx_pkg::TIME_W-1:0]     break_debounce_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b1;
            break_debounce_reg <= dmx_pkg::DEBOUNCE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                dmx_pkg::CFG_ENABLE:   enable_reg         <= cfg.data[0];
                dmx_pkg::CFG_DEBOUNCE: break_debounce_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame control state
    // ------------------------------------------------------------------
    logic                           active_bank_reg,      active_bank_next;
    logic [LEN_W-1:0]               open_length_reg,      open_length_next;
    logic [LEN_W-1:0]               published_length_reg, published_length_next;
    logic                           frame_open_reg,       frame_open_next;
    logic                           synced_reg,           synced_next;
    logic                           break_seen_reg,       break_seen_next;
    logic [dmx_pkg::TIME_W-1:0]     last_break_time_reg,  last_break_time_next;

    // Read stage (store read in flight) and output register
    logic                           s1_valid_reg;
    logic                           s1_pub_reg;
    logic [dmx_pkg::COUNT_W-1:0]    s1_count_reg;
    logic                           s1_acc_reg;
    logic                           s1_rvalid_reg;
    logic                           out_valid_reg;
    logic                           out_pub_reg;
    logic [dmx_pkg::COUNT_W-1:0]    out_count_reg;
    logic                           out_acc_reg;
    logic [dmx_pkg::BYTE_W-1:0]     out_data_reg;
    logic                           out_rvalid_reg;

    logic                           accept;
    logic                           s1_adv;
    logic                           debounced;
    logic [dmx_pkg::TIME_W-1:0]     since_last;
    logic                           pub_now;
    logic [dmx_pkg::COUNT_W-1:0]    count_now;
    logic                           acc_now;
    logic                           rvalid_now;
    logic                           wr_en;
    logic [ADDR_W-1:0]              wr_addr;
    logic [ADDR_W-1:0]              rd_addr;

    // Advance the read stage when the output register is free or being drained.
    assign s1_adv     = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_adv;
    assign accept     = item.valid && item.ready;

    assign since_last = item.break_time - last_break_time_reg;
    assign debounced  = break_seen_reg && (since_last < break_debounce_reg);

    // Writes land in the filling bank, reads come from the published one, so a read never
    // meets a write to the same entry in one cycle; a later read sees an earlier write.
    assign wr_addr = {active_bank_reg, open_length_reg[SLOT_W-1:0]};
    assign rd_addr = {~active_bank_reg, item.read_slot[SLOT_W-1:0]};

    always_comb
    begin
        active_bank_next      = active_bank_reg;
        open_length_next      = open_length_reg;
        published_length_next = published_length_reg;
        frame_open_next       = frame_open_reg;
        synced_next           = synced_reg;
        break_seen_next       = break_seen_reg;
        last_break_time_next  = last_break_time_reg;
        pub_now               = 1'b0;
        count_now             = '0;
        acc_now               = 1'b0;
        rvalid_now            = 1'b0;
        wr_en                 = 1'b0;

        if (item.opcode == dmx_pkg::OP_RESTART)
        begin
            // Restart drops the frame and the debounce reference, regardless of enable.
            frame_open_next      = 1'b0;
            open_length_next     = '0;
            synced_next          = 1'b0;
            break_seen_next      = 1'b0;
            last_break_time_next = '0;
        end
        else if (enable_reg)
        begin
            case (item.opcode)
                dmx_pkg::OP_BYTE:
                begin
                    // Store the slot while the frame is open and not yet full.
                    if (frame_open_reg && (open_length_reg < LEN_FULL))
                    begin
                        wr_en            = 1'b1;
                        open_length_next = open_length_reg + LEN_ONE;
                    end
                end
                dmx_pkg::OP_BREAK:
                begin
                    if (!debounced)
                    begin
                        acc_now              = 1'b1;
                        break_seen_next      = 1'b1;
                        last_break_time_next = item.break_time;
                        if (frame_open_reg && (open_length_reg != '0))
                        begin
                            // First frame after restart only brings the receiver into sync.
                            if (!synced_reg)
                            begin
                                synced_next = 1'b1;
                            end
                            else if (open_length_reg >= LEN_TWO)
                            begin
                                published_length_next = open_length_reg;
                                active_bank_next      = ~active_bank_reg;
                                pub_now               = 1'b1;
                                count_now = dmx_pkg::COUNT_W'(open_length_reg - LEN_ONE);
                            end
                        end
                        open_length_next = '0;
                        frame_open_next  = 1'b1;
                    end
                end
                dmx_pkg::OP_OVERFLOW:
                begin
                    // Abort the frame; drop bytes until the next accepted break.
                    frame_open_next  = 1'b0;
                    open_length_next = '0;
                end
                dmx_pkg::OP_READ:
                begin
                    rvalid_now = CMP_W'(item.read_slot) < CMP_W'(published_length_reg);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_bank_reg      <= 1'b0;
            open_length_reg      <= '0;
            published_length_reg <= '0;
            frame_open_reg       <= 1'b0;
            synced_reg           <= 1'b0;
            break_seen_reg       <= 1'b0;
            last_break_time_reg  <= '0;
        end
        else if (accept)
        begin
            active_bank_reg      <= active_bank_next;
            open_length_reg      <= open_length_next;
            published_length_reg <= published_length_next;
            frame_open_reg       <= frame_open_next;
            synced_reg           <= synced_next;
            break_seen_reg       <= break_seen_next;
            last_break_time_reg  <= last_break_time_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-bank slot store: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [dmx_pkg::BYTE_W-1:0] frame_mem [MEM_DEPTH];
    logic [dmx_pkg::BYTE_W-1:0] ram_q;

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            frame_mem[wr_addr] <= item.data_byte;
        end
    end

    // Hold the read data while the read stage is stalled.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ram_q <= frame_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Read stage and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= accept;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pub_reg    <= pub_now;
            s1_count_reg  <= count_now;
            s1_acc_reg    <= acc_now;
            s1_rvalid_reg <= rvalid_now;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_pub_reg    <= s1_pub_reg;
            out_count_reg  <= s1_count_reg;
            out_acc_reg    <= s1_acc_reg;
            out_rvalid_reg <= s1_rvalid_reg;
            out_data_reg   <= s1_rvalid_reg ? ram_q : '0;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.frame_published = out_pub_reg;
    assign result.channel_count   = out_count_reg;
    assign result.break_accepted  = out_acc_reg;
    assign result.read_data       = out_data_reg;
    assign result.read_valid      = out_rvalid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Store output may hold an unwritten (unknown) entry for a non-read beat; compare exactly.
    `DMX_ASSERT_SAME(a_len_bound, 1'b1, open_length_reg <= LEN_FULL,
                     "open length past frame size")
    `DMX_ASSERT_NEXT(a_bank_swap, accept && pub_now,
                     active_bank_reg != $past(active_bank_reg), "publish without bank swap")
    `DMX_ASSERT_NEXT(a_read_hold, s1_valid_reg && !s1_adv, ram_q === $past(ram_q),
                     "store read data lost while stalled")
    `DMX_ASSERT_SAME(a_pub_count, out_valid_reg && out_pub_reg,
                     (out_count_reg != '0) && !out_rvalid_reg, "bad publish result")

endmodule
